// File: rtl/assert_macros.svh
// Assertion macros used by the RTL (included by jsu_rsp_queue).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int MAX_ITEMS   = 4;

   typedef logic [LENGTH_BITS-1:0] count_type;
   typedef logic [15:0]            len_type;
   typedef logic [2:0]             status_type;
   typedef logic [2:0]             nitem_type;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_BAD_HEX   = 3'd1;
   localparam status_type ST_BAD_SURR  = 3'd2;
   localparam status_type ST_BAD_ESC   = 3'd3;
   localparam status_type ST_NO_QUOTE  = 3'd4;
   localparam status_type ST_CTRL_CHAR = 3'd5;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      status_type status;
      len_type    string_length;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      nitem_type                     count;
      rsp_item_type [MAX_ITEMS-1:0]  items;
   } step_type;

endpackage

// File: rtl/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescaper: request handshake, decoder, result queue.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_byte_valid, rsp_done_res,
//           |           |                      | rsp_status, rsp_string_length, rsp_last
//
// A request is decoded in the cycle it is accepted; its results appear in the next cycle.
// A request giving k results holds the result queue until all k have left; the next
// request is taken in the cycle the last of them leaves, so 1 request per cycle for
// k <= 1 while rsp_stall is low. Requests that give no result do not occupy the queue.
// Reset clears parser state and the queue count; no clearing pass.
// rsp_stall holds the queue head; req_stall is high while the queue holds results, except as its last one leaves.
module json_string_unescape_utf8_core import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_string_length,
   output logic       rsp_last
);

   step_type     step;
   rsp_item_type head_item;
   logic         not_empty;
   logic         last_one;
   logic         req_accept;
   logic         rsp_pop;

   assign rsp_valid  = not_empty;
   assign rsp_pop    = not_empty && !rsp_stall;
   assign req_stall  = !(!not_empty || (last_one && !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   jsu_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .in_byte (req_in_byte),
      .step    (step)
   );

   jsu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .step      (step),
      .pop       (rsp_pop),
      .not_empty (not_empty),
      .last_one  (last_one),
      .head_item (head_item)
   );

   assign rsp_out_byte      = head_item.out_byte;
   assign rsp_byte_valid    = head_item.byte_valid;
   assign rsp_done_res      = head_item.done_res;
   assign rsp_status        = head_item.status;
   assign rsp_string_length = head_item.string_length;
   assign rsp_last          = head_item.last;

endmodule

// File: rtl/jsu_decoder.sv
// Parser state and per-byte decode: escapes, \u hex, surrogates, UTF-8 encode.
module jsu_decoder import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output step_type   step
);

   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_STR    = 4'd1;
   localparam logic [3:0] M_ESC    = 4'd2;
   localparam logic [3:0] M_HEX1   = 4'd3;
   localparam logic [3:0] M_SUR_BS = 4'd4;
   localparam logic [3:0] M_SUR_U  = 4'd5;
   localparam logic [3:0] M_HEX2   = 4'd6;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [LENGTH_BITS:0] COUNT_MAX = {1'b0, {LENGTH_BITS{1'b1}}};

   logic [3:0]  mode_ff, mode_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [15:0] high_unit_ff, high_unit_in;
   logic [15:0] code_accum_ff, code_accum_in;
   count_type   byte_count_ff, byte_count_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] accum_new;
   logic        do_enc;
   logic [20:0] code_pt;
   logic        fin;
   status_type  fin_status;
   nitem_type   emit_n;
   logic [3:0][7:0] ebytes;
   logic        clear_count;
   logic [LENGTH_BITS:0] count_sum;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(in_byte - 8'h37);
      end else if (in_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(in_byte - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign accum_new = {code_accum_ff[11:0], hex_val};

   always_comb begin
      mode_in       = mode_ff;
      hex_cnt_in    = hex_cnt_ff;
      high_unit_in  = high_unit_ff;
      code_accum_in = code_accum_ff;
      clear_count   = 1'b0;
      do_enc        = 1'b0;
      code_pt       = 21'd0;
      fin           = 1'b0;
      fin_status    = ST_OK;
      emit_n        = 3'd0;
      ebytes        = '0;

      case (mode_ff)
         M_STR: begin
            if (in_byte == CH_QUOTE) begin
               fin = 1'b1;
               fin_status = ST_OK;
            end else if (in_byte == CH_BSL) begin
               mode_in = M_ESC;
            end else if (in_byte == CH_NUL) begin
               fin = 1'b1;
               fin_status = ST_NO_QUOTE;
            end else if (in_byte < CH_SPACE) begin
               fin = 1'b1;
               fin_status = ST_CTRL_CHAR;
            end else begin
               emit_n = 3'd1;
               ebytes[0] = in_byte;
            end
         end
         M_ESC: begin
            mode_in = M_STR;
            emit_n  = 3'd1;
            case (in_byte)
               CH_QUOTE: ebytes[0] = 8'h22;
               CH_BSL:   ebytes[0] = 8'h5C;
               CH_SLASH: ebytes[0] = 8'h2F;
               CH_N:     ebytes[0] = 8'h0A;
               CH_B:     ebytes[0] = 8'h08;
               CH_F:     ebytes[0] = 8'h0C;
               CH_R:     ebytes[0] = 8'h0D;
               CH_T:     ebytes[0] = 8'h09;
               CH_U: begin
                  emit_n        = 3'd0;
                  mode_in       = M_HEX1;
                  hex_cnt_in    = 2'd0;
                  code_accum_in = 16'd0;
               end
               default: begin
                  emit_n     = 3'd0;
                  fin        = 1'b1;
                  fin_status = ST_BAD_ESC;
               end
            endcase
         end
         M_HEX1, M_HEX2: begin
            if (!hex_ok) begin
               fin        = 1'b1;
               fin_status = ST_BAD_HEX;
            end else begin
               code_accum_in = accum_new;
               if (hex_cnt_ff != 2'd3) begin
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end else begin
                  hex_cnt_in = 2'd0;
                  if (mode_ff == M_HEX1) begin
                     if (accum_new inside {[16'hD800:16'hDBFF]}) begin
                        high_unit_in = accum_new;
                        mode_in      = M_SUR_BS;
                     end else begin
                        mode_in = M_STR;
                        do_enc  = 1'b1;
                        code_pt = {5'd0, accum_new};
                     end
                  end else begin
                     if (accum_new inside {[16'hDC00:16'hDFFF]}) begin
                        mode_in = M_STR;
                        do_enc  = 1'b1;
                        code_pt = 21'h10000
                                + {1'b0, high_unit_ff[9:0], accum_new[9:0]};
                     end else begin
                        fin        = 1'b1;
                        fin_status = ST_BAD_SURR;
                     end
                  end
               end
            end
         end
         M_SUR_BS: begin
            if (in_byte == CH_BSL) begin
               mode_in = M_SUR_U;
            end else begin
               fin        = 1'b1;
               fin_status = ST_BAD_SURR;
            end
         end
         M_SUR_U: begin
            if (in_byte == CH_U) begin
               mode_in       = M_HEX2;
               hex_cnt_in    = 2'd0;
               code_accum_in = 16'd0;
            end else begin
               fin        = 1'b1;
               fin_status = ST_BAD_SURR;
            end
         end
         default: begin
            mode_in = M_IDLE;
            if (in_byte == CH_QUOTE) begin
               mode_in       = M_STR;
               clear_count   = 1'b1;
               hex_cnt_in    = 2'd0;
               code_accum_in = 16'd0;
               high_unit_in  = 16'd0;
            end
         end
      endcase

      if (do_enc) begin
         if (code_pt <= 21'h7F) begin
            emit_n    = 3'd1;
            ebytes[0] = code_pt[7:0];
         end else if (code_pt <= 21'h7FF) begin
            emit_n    = 3'd2;
            ebytes[0] = {3'b110, code_pt[10:6]};
            ebytes[1] = {2'b10, code_pt[5:0]};
         end else if (code_pt <= 21'hFFFF) begin
            emit_n    = 3'd3;
            ebytes[0] = {4'b1110, code_pt[15:12]};
            ebytes[1] = {2'b10, code_pt[11:6]};
            ebytes[2] = {2'b10, code_pt[5:0]};
         end else begin
            emit_n    = 3'd4;
            ebytes[0] = {5'b11110, code_pt[20:18]};
            ebytes[1] = {2'b10, code_pt[17:12]};
            ebytes[2] = {2'b10, code_pt[11:6]};
            ebytes[3] = {2'b10, code_pt[5:0]};
         end
      end

      if (fin) begin
         mode_in    = M_IDLE;
         hex_cnt_in = 2'd0;
      end
   end

   // Saturating byte count.
   assign count_sum = {1'b0, byte_count_ff} + (LENGTH_BITS+1)'(emit_n);

   always_comb begin
      if (clear_count) begin
         byte_count_in = '0;
      end else if (count_sum > COUNT_MAX) begin
         byte_count_in = COUNT_MAX[LENGTH_BITS-1:0];
      end else begin
         byte_count_in = count_sum[LENGTH_BITS-1:0];
      end
   end

   always_comb begin
      step.count = emit_n;
      step.items = '0;
      if (fin) begin
         step.count                  = 3'd1;
         step.items[0].done_res      = 1'b1;
         step.items[0].status        = fin_status;
         step.items[0].string_length = (fin_status == ST_OK) ?
                                       len_type'(byte_count_ff) : 16'd0;
         step.items[0].last          = 1'b1;
      end else begin
         for (int i = 0; i < MAX_ITEMS; i++) begin
            if (3'(i) < emit_n) begin
               step.items[i].out_byte   = ebytes[i];
               step.items[i].byte_valid = 1'b1;
               step.items[i].last       = (3'(i + 1) == emit_n);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         hex_cnt_ff    <= 2'd0;
         high_unit_ff  <= 16'd0;
         code_accum_ff <= 16'd0;
         byte_count_ff <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         hex_cnt_ff    <= hex_cnt_in;
         high_unit_ff  <= high_unit_in;
         code_accum_ff <= code_accum_in;
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

// File: rtl/jsu_rsp_queue.sv
// Result register: holds the up to four results of one request and drains them in order.
module jsu_rsp_queue import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_type     step,
   input  logic         pop,
   output logic         not_empty,
   output logic         last_one,
   output rsp_item_type head_item
);

`include "assert_macros.svh"

   rsp_item_type [MAX_ITEMS-1:0] q_ff;
   nitem_type                    cnt_ff;
   logic [1:0]                   head_ff;

   assign not_empty = (cnt_ff != 3'd0);
   assign last_one  = (cnt_ff == 3'd1);
   assign head_item = q_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         head_ff <= 2'd0;
      end else if (load) begin
         cnt_ff  <= step.count;
         head_ff <= 2'd0;
      end else if (pop) begin
         cnt_ff  <= cnt_ff - 3'd1;
         head_ff <= head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= step.items;
      end
   end

   `ASSERT_SAME(a_load_when_free, clock, reset, load, (cnt_ff == 3'd0) || (last_one && pop))
   `ASSERT_SAME(a_fits, clock, reset, 1'b1, ({1'b0, head_ff} + cnt_ff) <= 3'd4)
   `ASSERT_SAME(a_tail_is_last, clock, reset, last_one, q_ff[head_ff].last)
   `ASSERT_NEXT(a_pop_count, clock, reset, pop && !load, cnt_ff == $past(cnt_ff) - 3'd1)

endmodule

// File: tb/json_string_unescape_utf8_core_tb.sv
// Self-checking testbench for the JSON string unescaper core with an unescape and UTF-8 encode scoreboard.
`timescale 1ns / 100ps

module json_string_unescape_utf8_core_tb import jsu_pkg::*; ();

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] ESCAPE_LETTERS [8] =
      '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 240;

   class unescape_scoreboard;
      typedef enum logic [3:0] {
         PM_IDLE, PM_TEXT, PM_ESCAPE, PM_UNIT1, PM_SUR_BSLASH, PM_SUR_U, PM_UNIT2
      } parse_mode_type;

      parse_mode_type mode = PM_IDLE;
      logic [1:0]   digit_cnt = '0;
      logic [15:0]  high_unit = '0;
      logic [15:0]  unit_acc = '0;
      count_type    decoded_len = '0;
      rsp_item_type decoded_items[$];
      rsp_item_type step_items[$];
      int           mismatches = 0;

      function int hex_value(logic [7:0] ch);
         if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 8'h30;
         if (ch >= 8'h41 && ch <= 8'h46) return int'(ch) - 8'h41 + 10;
         if (ch >= 8'h61 && ch <= 8'h66) return int'(ch) - 8'h61 + 10;
         return -1;
      endfunction

      function int pending();
         return decoded_items.size();
      endfunction

      function void put_byte(logic [7:0] b);
         rsp_item_type it;
         it = '0;
         it.out_byte = b;
         it.byte_valid = 1'b1;
         step_items.push_back(it);
         if (decoded_len != '1) decoded_len++;
      endfunction

      function void end_string(status_type st);
         rsp_item_type it;
         it = '0;
         it.done_res = 1'b1;
         it.status = st;
         if (st == ST_OK) it.string_length = len_type'(decoded_len);
         step_items.push_back(it);
         mode = PM_IDLE;
         digit_cnt = '0;
      endfunction

      function void put_code(logic [20:0] u);
         if (u <= 21'h7F) begin
            put_byte(u[7:0]);
         end else if (u <= 21'h7FF) begin
            put_byte(8'hC0 | u[10:6]);
            put_byte(8'h80 | u[5:0]);
         end else if (u <= 21'hFFFF) begin
            put_byte(8'hE0 | u[15:12]);
            put_byte(8'h80 | u[11:6]);
            put_byte(8'h80 | u[5:0]);
         end else begin
            put_byte(8'hF0 | u[20:18]);
            put_byte(8'h80 | u[17:12]);
            put_byte(8'h80 | u[11:6]);
            put_byte(8'h80 | u[5:0]);
         end
      endfunction

      function void decode_request(logic [7:0] ch);
         int           h;
         logic [20:0]  cp;
         rsp_item_type tail;
         step_items.delete();
         case (mode)
            PM_TEXT: begin
               if (ch == CH_QUOTE) end_string(ST_OK);
               else if (ch == CH_BSLASH) mode = PM_ESCAPE;
               else if (ch == 8'h00) end_string(ST_NO_QUOTE);
               else if (ch < 8'h20) end_string(ST_CTRL_CHAR);
               else put_byte(ch);
            end
            PM_ESCAPE: begin
               mode = PM_TEXT;
               case (ch)
                  CH_QUOTE, CH_BSLASH, 8'h2F: put_byte(ch);
                  8'h6E: put_byte(8'h0A);
                  8'h62: put_byte(8'h08);
                  8'h66: put_byte(8'h0C);
                  8'h72: put_byte(8'h0D);
                  8'h74: put_byte(8'h09);
                  CH_U: begin
                     mode = PM_UNIT1;
                     digit_cnt = '0;
                     unit_acc = '0;
                  end
                  default: end_string(ST_BAD_ESC);
               endcase
            end
            PM_UNIT1, PM_UNIT2: begin
               h = hex_value(ch);
               if (h < 0) begin
                  end_string(ST_BAD_HEX);
               end else begin
                  unit_acc = {unit_acc[11:0], 4'(h)};
                  if (digit_cnt != 2'd3) begin
                     digit_cnt++;
                  end else begin
                     digit_cnt = '0;
                     if (mode == PM_UNIT1) begin
                        if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                           high_unit = unit_acc;
                           mode = PM_SUR_BSLASH;
                        end else begin
                           mode = PM_TEXT;
                           put_code({5'd0, unit_acc});
                        end
                     end else if (unit_acc < 16'hDC00 || unit_acc > 16'hDFFF) begin
                        end_string(ST_BAD_SURR);
                     end else begin
                        cp = {1'b0, high_unit[9:0], unit_acc[9:0]} + 21'h10000;
                        mode = PM_TEXT;
                        put_code(cp);
                     end
                  end
               end
            end
            PM_SUR_BSLASH: begin
               if (ch == CH_BSLASH) mode = PM_SUR_U;
               else end_string(ST_BAD_SURR);
            end
            PM_SUR_U: begin
               if (ch == CH_U) begin
                  mode = PM_UNIT2;
                  digit_cnt = '0;
                  unit_acc = '0;
               end else begin
                  end_string(ST_BAD_SURR);
               end
            end
            default: begin
               if (ch == CH_QUOTE) begin
                  mode = PM_TEXT;
                  decoded_len = '0;
                  digit_cnt = '0;
                  unit_acc = '0;
                  high_unit = '0;
               end else begin
                  mode = PM_IDLE;
               end
            end
         endcase
         if (step_items.size() > 0) begin
            tail = step_items.pop_back();
            tail.last = 1'b1;
            step_items.push_back(tail);
         end
         foreach (step_items[i]) decoded_items.push_back(step_items[i]);
      endfunction

      function void report(string what, rsp_item_type want, rsp_item_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t %s: expected byte=%h bv=%b done=%b st=%0d len=%0d last=%b",
                     $time, what, want.out_byte, want.byte_valid, want.done_res,
                     want.status, want.string_length, want.last);
            $display("   got byte=%h bv=%b done=%b st=%0d len=%0d last=%b",
                     got.out_byte, got.byte_valid, got.done_res, got.status,
                     got.string_length, got.last);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (decoded_items.size() == 0) begin
            report("unexpected result", '0, got);
         end else begin
            want = decoded_items.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.done_res !== want.done_res || got.status !== want.status ||
                got.string_length !== want.string_length || got.last !== want.last)
               report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_string_length;
   logic        rsp_last;

   unescape_scoreboard sb;
   logic [7:0]  tx_text[$];
   int          burst_left = 0;
   int          random_sent = 0;
   int          quiet_cycles = 0;
   int          stall_kind = 0;
   int          stall_left = 0;
   int          cycle_no = 0;

   json_string_unescape_utf8_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycle_no % 5) < 2;
      endcase
   end

   always @(posedge clock) begin
      rsp_item_type seen;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.decode_request(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            seen.out_byte = rsp_out_byte;
            seen.byte_valid = rsp_byte_valid;
            seen.done_res = rsp_done_res;
            seen.status = rsp_status;
            seen.string_length = rsp_string_length;
            seen.last = rsp_last;
            sb.check_result(seen);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + (nib - 4'd10);
   endfunction

   function automatic void add_unit(logic [15:0] v);
      tx_text.push_back(CH_BSLASH);
      tx_text.push_back(CH_U);
      for (int i = 3; i >= 0; i--) tx_text.push_back(hex_char(v[i*4 +: 4]));
   endfunction

   function automatic logic [15:0] high_surrogate();
      return 16'($urandom_range(16'hD800, 16'hDBFF));
   endfunction

   function automatic void add_token();
      int          r;
      logic [15:0] v;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         tx_text.push_back(plain_char());
      end else if (r < 60) begin
         tx_text.push_back(CH_BSLASH);
         tx_text.push_back(ESCAPE_LETTERS[3'($urandom_range(0, 7))]);
      end else if (r < 75) begin
         case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(16'h0000, 16'h007F));
            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
            2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
            default: v = 16'($urandom_range(16'hE000, 16'hFFFF));
         endcase
         add_unit(v);
      end else if (r < 92) begin
         add_unit(high_surrogate());
         add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else begin
         add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
   endfunction

   function automatic void add_good_string();
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
      tx_text.push_back(CH_QUOTE);
      repeat (n) add_token();
      tx_text.push_back(CH_QUOTE);
   endfunction

   function automatic void add_broken_string();
      logic [7:0]  c;
      logic [15:0] v;
      tx_text.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) add_token();
      case ($urandom_range(0, 6))
         0: begin
            tx_text.push_back(CH_BSLASH);
            if ($urandom_range(0, 5) == 0) c = 8'h00;
            else do c = 8'($urandom); while (c inside {ESCAPE_LETTERS[0], ESCAPE_LETTERS[1],
               ESCAPE_LETTERS[2], ESCAPE_LETTERS[3], ESCAPE_LETTERS[4], ESCAPE_LETTERS[5],
               ESCAPE_LETTERS[6], ESCAPE_LETTERS[7], CH_U});
            tx_text.push_back(c);
         end
         1: begin
            tx_text.push_back(CH_BSLASH);
            tx_text.push_back(CH_U);
            repeat ($urandom_range(0, 3))
               tx_text.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 5) == 0) c = 8'h00;
            else do c = 8'($urandom); while (sb.hex_value(c) >= 0);
            tx_text.push_back(c);
         end
         2: begin
            add_unit(high_surrogate());
            do c = 8'($urandom); while (c == CH_BSLASH);
            tx_text.push_back(c);
         end
         3: begin
            add_unit(high_surrogate());
            tx_text.push_back(CH_BSLASH);
            do c = 8'($urandom); while (c == CH_U);
            tx_text.push_back(c);
         end
         4: begin
            add_unit(high_surrogate());
            do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
            add_unit(v);
         end
         5: tx_text.push_back(8'h00);
         default: tx_text.push_back(8'($urandom_range(8'h01, 8'h1F)));
      endcase
   endfunction

   function automatic void add_noise();
      logic [7:0] c;
      repeat ($urandom_range(1, 5)) begin
         do c = 8'($urandom); while (c == CH_QUOTE);
         tx_text.push_back(c);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input bit counted);
      foreach (tx_text[i]) begin
         send_byte(tx_text[i]);
         if (counted) random_sent++;
      end
      tx_text.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   initial begin
      bit drained;
      int r;
      drained = 1'b0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, largest code point, lone low surrogate, then each error ending
      tx_text = '{8'h00, CH_QUOTE, 8'h20, 8'hFF};
      add_unit(16'hDBFF);
      add_unit(16'hDFFF);
      add_unit(16'hDC00);
      tx_text.push_back(CH_QUOTE);
      tx_text.push_back(CH_QUOTE);
      tx_text.push_back(CH_BSLASH);
      tx_text.push_back(8'h71);
      tx_text.push_back(CH_QUOTE);
      tx_text.push_back(8'h00);
      tx_text.push_back(CH_QUOTE);
      tx_text.push_back(8'h1F);
      tx_text.push_back(CH_QUOTE);
      tx_text.push_back(CH_BSLASH);
      tx_text.push_back(CH_U);
      tx_text.push_back(8'h67);
      tx_text.push_back(CH_QUOTE);
      add_unit(16'hD800);
      tx_text.push_back(8'h78);
      send_text(1'b0);

      while (random_sent < RANDOM_REQUESTS) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            add_good_string();
            send_text(1'b1);
         end else if (r < 90) begin
            add_broken_string();
            send_text(1'b1);
         end else begin
            add_noise();
            send_text(1'b0);
         end
         if (!drained && random_sent >= RANDOM_REQUESTS / 2) begin
            wait_drained();
            drained = 1'b1;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decoder.sv
rtl/jsu_rsp_queue.sv
rtl/json_string_unescape_utf8_core.sv
tb/json_string_unescape_utf8_core_tb.sv
